// ===== rtl/rv64_word_ops_execute_defines.svh =====
`ifndef RV64_WORD_OPS_EXECUTE_DEFINES_SVH
`define RV64_WORD_OPS_EXECUTE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RVW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RVW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rvw_pkg.sv =====
package rvw_pkg;

	localparam int unsigned XLEN     = 64;
	localparam int unsigned REG_IDXW = 5;
	localparam int unsigned NUM_REGS = 32;

	typedef enum logic [3:0] {
		ACT_LWU   = 4'd0,
		ACT_LD    = 4'd1,
		ACT_SD    = 4'd2,
		ACT_ADDIW = 4'd3,
		ACT_SLLIW = 4'd4,
		ACT_SRLIW = 4'd5,
		ACT_SRAIW = 4'd6,
		ACT_ADDW  = 4'd7,
		ACT_SUBW  = 4'd8,
		ACT_SLLW  = 4'd9,
		ACT_SRLW  = 4'd10,
		ACT_SRAW  = 4'd11
	} action_t;

	typedef enum logic [1:0] {
		ACC_NONE  = 2'd0,
		ACC_RD32  = 2'd1,
		ACC_RD64  = 2'd2,
		ACC_WR64  = 2'd3
	} access_t;

	typedef struct packed {
		logic [3:0]          action;
		logic [REG_IDXW-1:0] dest_reg;
		logic [REG_IDXW-1:0] src_a_reg;
		logic [REG_IDXW-1:0] src_b_reg;
		logic signed [11:0]  immediate;
		logic [4:0]          shift_amount;
		logic [XLEN-1:0]     load_data;
	} req_t;

	typedef struct packed {
		logic [1:0]          bus_access;
		logic [XLEN-1:0]     bus_address;
		logic [XLEN-1:0]     store_value;
		logic                write_enable;
		logic [REG_IDXW-1:0] write_index;
		logic [XLEN-1:0]     write_value;
	} rsp_t;

	// register file write port
	typedef struct packed {
		logic                en;
		logic [REG_IDXW-1:0] idx;
		logic [XLEN-1:0]     data;
	} wb_t;

endpackage

// ===== rtl/rvw_regfile.sv =====
module rvw_regfile
	import rvw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [REG_IDXW-1:0] rd_a_idx,
	input  logic [REG_IDXW-1:0] rd_b_idx,
	output logic [XLEN-1:0]     rd_a_s1,
	output logic [XLEN-1:0]     rd_b_s1,
	input  wb_t                 wb
);

	logic [XLEN-1:0]     mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;

	// entry not yet written reads as zero; x0 is never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wb.en) begin
			vld_q[wb.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb.idx] <= wb.data;
		end
	end

	// registered read with write-through so a write is visible to the next word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wb.en && wb.idx == rd_a_idx) begin
				rd_a_s1 <= wb.data;
			end else if (vld_q[rd_a_idx]) begin
				rd_a_s1 <= mem[rd_a_idx];
			end else begin
				rd_a_s1 <= '0;
			end
			if (wb.en && wb.idx == rd_b_idx) begin
				rd_b_s1 <= wb.data;
			end else if (vld_q[rd_b_idx]) begin
				rd_b_s1 <= mem[rd_b_idx];
			end else begin
				rd_b_s1 <= '0;
			end
		end
	end

endmodule

// ===== rtl/rvw_alu.sv =====
module rvw_alu
	import rvw_pkg::*;
(
	input  req_t            op,
	input  logic [XLEN-1:0] a,
	input  logic [XLEN-1:0] b,
	output rsp_t            res
);

	logic [XLEN-1:0] imm_x;
	logic [XLEN-1:0] addr;
	logic [31:0]     add_i;
	logic [31:0]     add_r;
	logic [31:0]     sub_r;
	logic [4:0]      sh;
	logic [31:0]     sll_r;
	logic [31:0]     srl_r;
	logic [31:0]     sra_r;
	logic [1:0]      acc;
	logic [XLEN-1:0] st;
	logic [XLEN-1:0] val;
	logic            wr;

	always_comb begin
		imm_x = {{(XLEN-12){op.immediate[11]}}, op.immediate};
		addr  = a + imm_x;
		add_i = a[31:0] + imm_x[31:0];
		add_r = a[31:0] + b[31:0];
		sub_r = a[31:0] - b[31:0];
		// immediate shifts take the encoded count, register shifts take b[4:0]
		if (op.action == ACT_SLLIW || op.action == ACT_SRLIW || op.action == ACT_SRAIW) begin
			sh = op.shift_amount;
		end else begin
			sh = b[4:0];
		end
		sll_r = a[31:0] << sh;
		srl_r = a[31:0] >> sh;
		sra_r = $signed(a[31:0]) >>> sh;
	end

	always_comb begin
		acc = ACC_NONE;
		st  = '0;
		val = '0;
		wr  = 1'b0;
		unique case (op.action)
			ACT_LWU: begin
				acc = ACC_RD32;
				val = {32'd0, op.load_data[31:0]};
				wr  = 1'b1;
			end
			ACT_LD: begin
				acc = ACC_RD64;
				val = op.load_data;
				wr  = 1'b1;
			end
			ACT_SD: begin
				acc = ACC_WR64;
				st  = b;
			end
			ACT_ADDIW: begin
				val = {{32{add_i[31]}}, add_i};
				wr  = 1'b1;
			end
			ACT_ADDW: begin
				val = {{32{add_r[31]}}, add_r};
				wr  = 1'b1;
			end
			ACT_SUBW: begin
				val = {{32{sub_r[31]}}, sub_r};
				wr  = 1'b1;
			end
			ACT_SLLIW, ACT_SLLW: begin
				val = {{32{sll_r[31]}}, sll_r};
				wr  = 1'b1;
			end
			ACT_SRLIW, ACT_SRLW: begin
				val = {{32{srl_r[31]}}, srl_r};
				wr  = 1'b1;
			end
			ACT_SRAIW, ACT_SRAW: begin
				val = {{32{sra_r[31]}}, sra_r};
				wr  = 1'b1;
			end
			default: begin
				// undefined codes are a no-op
				wr = 1'b0;
			end
		endcase

		if (op.dest_reg == '0) begin
			wr = 1'b0;
		end

		res.bus_access   = acc;
		res.bus_address  = (acc != ACC_NONE) ? addr : '0;
		res.store_value  = st;
		res.write_enable = wr;
		res.write_index  = wr ? op.dest_reg : '0;
		res.write_value  = wr ? val : '0;
	end

endmodule

// ===== rtl/rv64_word_ops_execute.sv =====
// channel | handshake             | word
// --------+-----------------------+-------------------------------------------
// req     | req_valid / req_stall | req_t: action, registers, imm, load data
// rsp     | rsp_valid / rsp_stall | rsp_t: bus access, address, store, writeback
//
// After accept the operands are registered into the execute stage; when that
// stage advances, the executed result and rsp_valid are registered into rsp.
// One word per cycle sustained while rsp is not stalled; register file
// write-through lets the next word read a value written by the one ahead.
// Reset clears valid flags and register-file valid bits (all registers read 0).
// A stalled result holds the execute stage, which then stalls req.
`include "rv64_word_ops_execute_defines.svh"

module rv64_word_ops_execute
	import rvw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic            valid_s1;
	req_t            req_s1;
	logic [XLEN-1:0] a_s1;
	logic [XLEN-1:0] b_s1;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	rsp_t            res;
	logic            advance;
	logic            accept;
	wb_t             wb;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	rvw_regfile u_rf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_a_idx (req.src_a_reg),
		.rd_b_idx (req.src_b_reg),
		.rd_a_s1  (a_s1),
		.rd_b_s1  (b_s1),
		.wb       (wb)
	);

	rvw_alu u_alu (
		.op  (req_s1),
		.a   (a_s1),
		.b   (b_s1),
		.res (res)
	);

	always_comb begin
		wb.en   = advance && res.write_enable;
		wb.idx  = res.write_index;
		wb.data = res.write_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RVW_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid_q, "executed word did not reach rsp")
	`RVW_ASSERT_IMPL(a_no_x0_write, wb.en, wb.idx != '0, "write to register zero")
	`RVW_ASSERT_IMPL(a_idle_wb_clear,
		rsp_valid_q && !rsp_q.write_enable,
		rsp_q.write_index == '0 && rsp_q.write_value == '0,
		"writeback fields not cleared")
	`RVW_ASSERT_IMPL(a_no_bus_addr,
		rsp_valid_q && rsp_q.bus_access == ACC_NONE,
		rsp_q.bus_address == '0 && rsp_q.store_value == '0,
		"bus fields set without access")

endmodule
